[rtl/core/lsq_pkg.sv]
// Shared types and constants for the loop step quantizer.
package lsq_pkg;

    localparam int STEP_W     = 8;
    localparam int FRAC_W     = 8;
    localparam int DUR_W      = 16;
    localparam int QDUR_W     = 17;
    localparam int THR_W      = 9;
    localparam int GRID_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DIVIDEND_W = 17;
    localparam int CNT_W      = 5;

    // step counts of the remainder unit for short and long dividends
    localparam logic [CNT_W-1:0] SHORT_STEPS = 5'd8;
    localparam logic [CNT_W-1:0] LONG_STEPS  = 5'd17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIVISION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_MODE       = 2'd3;

    // configuration reset values
    localparam logic [STEP_W-1:0] RST_LOOP_LENGTH     = 8'd16;
    localparam logic [GRID_W-1:0] RST_TARGET_DIVISION = 8'd1;
    localparam logic [THR_W-1:0]  RST_SNAP_THRESHOLD  = 9'd128;
    localparam logic              RST_SNAP_MODE       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT_INIT,
        ST_FIT_START,
        ST_FIT_RUN,
        ST_ITEM_START,
        ST_ITEM_RUN,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch_item;
        logic fit_init;
        logic fit_start;
        logic fit_next;
        logic fit_accept;
        logic item_start;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic stale;
        logic busy;
        logic fit_hit;
        logic out_free;
    } status_t;

endpackage

[rtl/core/lsq_if.sv]
// Item channel interfaces: note events in, quantized results out.
interface lsq_note_if;
    logic        valid;
    logic        ready;
    logic [7:0]  raw_step;
    logic [7:0]  step_fraction;
    logic [15:0] note_duration;

    modport source (output valid, raw_step, step_fraction, note_duration, input ready);
    modport sink   (input valid, raw_step, step_fraction, note_duration, output ready);
endinterface

interface lsq_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  snapped_step;
    logic [16:0] quantized_duration;
    logic [7:0]  grid_used;

    modport source (output valid, snapped_step, quantized_duration, grid_used, input ready);
    modport sink   (input valid, snapped_step, quantized_duration, grid_used, output ready);
endinterface

[rtl/core/loop_step_quantizer_core.sv]
// Loop step quantizer top level: controller, datapath and item channels.
// One note item in, one quantized result out. An item is taken in the idle
// state, and no new item is taken until its result has been loaded. The steps
// are: the idle state that takes the item, a setup state, a run state that
// waits on the 17-step bit-serial remainder unit that reduces the rounded
// duration modulo the grid plus the check after it (the step position runs
// alongside in a second unit), and a finish state that loads the result. The
// first item after reset or a write to loop_length or target_division first
// fits the grid: a setup step, then candidate divisors walked down from
// min(target, length), each with a start, a remainder run and a check; the
// longest walk is for loop length 251 with target 250. Results sit in an
// output register, so the next item can be accepted while a result waits to
// be taken; that item then holds in the finish state until the result is taken.
module loop_step_quantizer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    lsq_note_if.sink                       notes,
    lsq_result_if.source                   results,
    input  logic                           cfg_we,
    input  logic [lsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsq_pkg::CFG_DATA_W-1:0] cfg_data
);

    lsq_pkg::cmd_t    cmd;
    lsq_pkg::status_t status;

    lsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (notes.valid),
        .in_ready (notes.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsq_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .status             (status),
        .raw_step           (notes.raw_step),
        .step_fraction      (notes.step_fraction),
        .note_duration      (notes.note_duration),
        .out_valid          (results.valid),
        .out_ready          (results.ready),
        .snapped_step       (results.snapped_step),
        .quantized_duration (results.quantized_duration),
        .grid_used          (results.grid_used)
    );

endmodule

[rtl/core/lsq_mod.sv]
// Bit-serial restoring remainder unit: dividend mod an 8-bit divisor.
module lsq_mod (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             short_mode,
    input  logic [lsq_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [lsq_pkg::GRID_W-1:0]       divisor,
    output logic                             busy,
    output logic [lsq_pkg::GRID_W-1:0]       rem
);

    logic [lsq_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [lsq_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [lsq_pkg::GRID_W-1:0]     rem_reg, rem_next;
    logic [lsq_pkg::GRID_W-1:0]     div_reg, div_next;
    logic [lsq_pkg::GRID_W:0]       trial;

    // one dividend bit shifted in per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        trial    = {rem_reg, quo_reg[lsq_pkg::DIVIDEND_W-1]};
        if (start)
        begin
            div_next = divisor;
            rem_next = '0;
            if (short_mode)
            begin
                quo_next = {dividend[lsq_pkg::STEP_W-1:0],
                            {(lsq_pkg::DIVIDEND_W - lsq_pkg::STEP_W){1'b0}}};
                cnt_next = lsq_pkg::SHORT_STEPS;
            end
            else
            begin
                quo_next = dividend;
                cnt_next = lsq_pkg::LONG_STEPS;
            end
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = lsq_pkg::GRID_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[lsq_pkg::GRID_W-1:0];
            quo_next = {quo_reg[lsq_pkg::DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

[rtl/core/lsq_dp.sv]
// Datapath: configuration, grid fitting, step snap and duration rounding.
module lsq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  lsq_pkg::cmd_t                    cmd,
    output lsq_pkg::status_t                 status,
    input  logic [lsq_pkg::STEP_W-1:0]       raw_step,
    input  logic [lsq_pkg::FRAC_W-1:0]       step_fraction,
    input  logic [lsq_pkg::DUR_W-1:0]        note_duration,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lsq_pkg::STEP_W-1:0]       snapped_step,
    output logic [lsq_pkg::QDUR_W-1:0]       quantized_duration,
    output logic [lsq_pkg::GRID_W-1:0]       grid_used
);

    // configuration and held grid
    logic [lsq_pkg::STEP_W-1:0] loop_len_reg;
    logic [lsq_pkg::GRID_W-1:0] target_reg;
    logic [lsq_pkg::THR_W-1:0]  thr_reg;
    logic                       mode_reg;
    logic                       stale_reg;
    logic [lsq_pkg::GRID_W-1:0] grid_reg;
    logic [lsq_pkg::GRID_W-1:0] cand_reg;

    // item operands
    logic [lsq_pkg::STEP_W-1:0]       r_reg;
    logic [lsq_pkg::FRAC_W-1:0]       frac_reg;
    logic [lsq_pkg::DUR_W-1:0]        dur_reg;
    logic [lsq_pkg::GRID_W-1:0]       g_reg;
    logic [lsq_pkg::QDUR_W-1:0]       n_reg;
    logic [lsq_pkg::QDUR_W-1:0]       thr_prod_reg;

    // result register
    logic                             out_valid_reg;
    logic [lsq_pkg::STEP_W-1:0]       step_out_reg;
    logic [lsq_pkg::QDUR_W-1:0]       qdur_out_reg;
    logic [lsq_pkg::GRID_W-1:0]       grid_out_reg;

    logic [lsq_pkg::GRID_W-1:0]       fit_min;
    logic [lsq_pkg::GRID_W-1:0]       g_comb;
    logic [lsq_pkg::QDUR_W-1:0]       n_comb;
    logic                             moda_start;
    logic [lsq_pkg::DIVIDEND_W-1:0]   moda_dividend;
    logic [lsq_pkg::GRID_W-1:0]       moda_divisor;
    logic                             moda_busy;
    logic [lsq_pkg::GRID_W-1:0]       moda_rem;
    logic                             modb_busy;
    logic [lsq_pkg::GRID_W-1:0]       modb_rem;

    logic [lsq_pkg::STEP_W-1:0]       base;
    logic [lsq_pkg::QDUR_W-1:0]       lhs;
    logic                             fwd;
    logic [lsq_pkg::STEP_W+1:0]       step_fwd;
    logic [lsq_pkg::STEP_W-1:0]       step_sel;
    logic [lsq_pkg::QDUR_W-1:0]       trunc;
    logic [lsq_pkg::QDUR_W-1:0]       qdur_sel;

    function automatic logic [lsq_pkg::QDUR_W-1:0] QDUR_W_ZX(input logic [lsq_pkg::GRID_W-1:0] v);
        QDUR_W_ZX = {{(lsq_pkg::QDUR_W - lsq_pkg::GRID_W){1'b0}}, v};
    endfunction

    // configuration writes; a grid-relevant write marks the grid stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_len_reg <= lsq_pkg::RST_LOOP_LENGTH;
            target_reg   <= lsq_pkg::RST_TARGET_DIVISION;
            thr_reg      <= lsq_pkg::RST_SNAP_THRESHOLD;
            mode_reg     <= lsq_pkg::RST_SNAP_MODE;
            stale_reg    <= 1'b1;
            grid_reg     <= 8'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lsq_pkg::REG_LOOP_LENGTH:
                    begin
                        loop_len_reg <= cfg_data[lsq_pkg::STEP_W-1:0];
                        stale_reg    <= 1'b1;
                    end
                    lsq_pkg::REG_TARGET_DIVISION:
                    begin
                        target_reg <= cfg_data[lsq_pkg::GRID_W-1:0];
                        stale_reg  <= 1'b1;
                    end
                    lsq_pkg::REG_SNAP_THRESHOLD:
                        thr_reg <= cfg_data;
                    lsq_pkg::REG_SNAP_MODE:
                        mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.fit_accept)
            begin
                grid_reg  <= cand_reg;
                stale_reg <= 1'b0;
            end
        end
    end

    // divisor search starts at min(target, length), at least 1
    always_comb
    begin
        fit_min = (target_reg < loop_len_reg) ? target_reg : loop_len_reg;
        if (fit_min == '0)
            fit_min = 8'd1;
    end

    assign g_comb = mode_reg ? grid_reg : 8'd1;
    assign n_comb = {1'b0, dur_reg} + QDUR_W_ZX(g_comb >> 1);

    // operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.fit_init)
            cand_reg <= fit_min;
        else if (cmd.fit_next)
            cand_reg <= cand_reg - 1'b1;
        if (cmd.latch_item)
        begin
            r_reg    <= (raw_step == '0) ? '0 : raw_step - 1'b1;
            frac_reg <= step_fraction;
            dur_reg  <= note_duration;
        end
        if (cmd.item_start)
        begin
            g_reg        <= g_comb;
            n_reg        <= n_comb;
            thr_prod_reg <= lsq_pkg::QDUR_W'(thr_reg * g_comb);
        end
    end

    // unit A: grid fitting and step position; unit B: duration remainder
    assign moda_start    = cmd.fit_start | cmd.item_start;
    assign moda_dividend = cmd.fit_start
                           ? {{(lsq_pkg::DIVIDEND_W - lsq_pkg::STEP_W){1'b0}}, loop_len_reg}
                           : {{(lsq_pkg::DIVIDEND_W - lsq_pkg::STEP_W){1'b0}}, r_reg};
    assign moda_divisor  = cmd.fit_start ? cand_reg : g_comb;

    lsq_mod u_moda (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (moda_start),
        .short_mode (1'b1),
        .dividend   (moda_dividend),
        .divisor    (moda_divisor),
        .busy       (moda_busy),
        .rem        (moda_rem)
    );

    lsq_mod u_modb (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.item_start),
        .short_mode (1'b0),
        .dividend   (n_comb),
        .divisor    (g_comb),
        .busy       (modb_busy),
        .rem        (modb_rem)
    );

    // snap: back to division start, or forward with wrap past loop end
    always_comb
    begin
        base     = r_reg - moda_rem;
        lhs      = {1'b0, moda_rem, frac_reg};
        fwd      = (lhs >= thr_prod_reg);
        step_fwd = {2'b00, base} + {2'b00, g_reg} + 10'd1;
        if (fwd)
        begin
            if (step_fwd > {2'b00, loop_len_reg})
                step_sel = 8'd1;
            else
                step_sel = step_fwd[lsq_pkg::STEP_W-1:0];
        end
        else
            step_sel = base + 1'b1;
    end

    // duration: round half-up to a grid multiple, at least one grid when the grid is above 1
    always_comb
    begin
        trunc = n_reg - QDUR_W_ZX(modb_rem);
        if (g_reg <= 8'd1)
            qdur_sel = {1'b0, dur_reg};
        else if (trunc < QDUR_W_ZX(g_reg))
            qdur_sel = QDUR_W_ZX(g_reg);
        else
            qdur_sel = trunc;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            step_out_reg <= step_sel;
            qdur_out_reg <= qdur_sel;
            grid_out_reg <= g_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign snapped_step       = step_out_reg;
    assign quantized_duration = qdur_out_reg;
    assign grid_used          = grid_out_reg;

    assign status.stale    = stale_reg;
    assign status.busy     = moda_busy | modb_busy;
    assign status.fit_hit  = (moda_rem == '0);
    assign status.out_free = ~out_valid_reg | out_ready;

endmodule

[rtl/core/lsq_ctrl.sv]
// Controller: sequences grid fitting and per-item remainder runs.
module lsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsq_pkg::status_t  status,
    output lsq_pkg::cmd_t     cmd
);

    lsq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lsq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lsq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next = status.stale ? lsq_pkg::ST_FIT_INIT : lsq_pkg::ST_ITEM_START;
                end
            end
            lsq_pkg::ST_FIT_INIT:
            begin
                cmd.fit_init = 1'b1;
                state_next   = lsq_pkg::ST_FIT_START;
            end
            lsq_pkg::ST_FIT_START:
            begin
                cmd.fit_start = 1'b1;
                state_next    = lsq_pkg::ST_FIT_RUN;
            end
            lsq_pkg::ST_FIT_RUN:
            begin
                if (!status.busy)
                begin
                    if (status.fit_hit)
                    begin
                        cmd.fit_accept = 1'b1;
                        state_next     = lsq_pkg::ST_ITEM_START;
                    end
                    else
                    begin
                        cmd.fit_next = 1'b1;
                        state_next   = lsq_pkg::ST_FIT_START;
                    end
                end
            end
            lsq_pkg::ST_ITEM_START:
            begin
                cmd.item_start = 1'b1;
                state_next     = lsq_pkg::ST_ITEM_RUN;
            end
            lsq_pkg::ST_ITEM_RUN:
            begin
                if (!status.busy)
                    state_next = lsq_pkg::ST_FINISH;
            end
            lsq_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lsq_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lsq_pkg::ST_IDLE;
        endcase
    end

endmodule

[tb/quantizer_checker.sv]
// Note quantization checker: predicts each result from the taken notes and compares it.
`timescale 1ns / 100ps

module quantizer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    lsq_note_if                            notes,
    lsq_result_if                          results,
    input  logic                           cfg_we,
    input  logic [lsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsq_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             failures,
    output int                             outstanding
);

    typedef struct {
        logic [lsq_pkg::STEP_W-1:0] step;
        logic [lsq_pkg::QDUR_W-1:0] qdur;
        logic [lsq_pkg::GRID_W-1:0] grid;
    } note_result_t;

    // shadow of the block's registers and held grid
    logic [lsq_pkg::STEP_W-1:0] loop_len;
    logic [lsq_pkg::GRID_W-1:0] tgt_div;
    logic [lsq_pkg::THR_W-1:0]  snap_thr;
    logic                       snap_grid;
    logic [lsq_pkg::GRID_W-1:0] held_grid;
    logic                       grid_stale;

    note_result_t quantized_notes[$];

    // Snap one note to the grid; refits the grid first if a length or target
    // write left it stale.
    function automatic note_result_t quantize_note(input logic [lsq_pkg::STEP_W-1:0] raw,
                                                   input logic [lsq_pkg::FRAC_W-1:0] frac,
                                                   input logic [lsq_pkg::DUR_W-1:0] dur);
        int lim;
        int g;
        int r;
        int pos;
        int slot;
        int step;
        int qd;
        note_result_t res;
        if (grid_stale) begin
            lim = (tgt_div < loop_len) ? tgt_div : loop_len;
            held_grid = 8'd1;
            // largest divisor of the loop not above the target; 1 if either is zero
            for (int c = 1; c <= lim; c++) begin
                if (loop_len % c == 0)
                    held_grid = lsq_pkg::GRID_W'(c);
            end
            grid_stale = 1'b0;
        end
        g = snap_grid ? held_grid : 1;

        // raw step zero counts as step 1
        r = (raw == 0) ? 0 : raw - 1;
        pos = r % g;
        slot = r / g;
        step = slot * g + 1;
        // exact forward test in Q0.8; thresholds above one never pass
        if (pos * 256 + frac >= snap_thr * g) begin
            step = (slot + 1) * g + 1;
            if (step > loop_len)
                step = 1;
        end

        if (g <= 1) begin
            qd = dur;
        end
        else begin
            qd = ((dur + g / 2) / g) * g;
            if (qd < g)
                qd = g;
        end

        res.step = lsq_pkg::STEP_W'(step);
        res.qdur = lsq_pkg::QDUR_W'(qd);
        res.grid = lsq_pkg::GRID_W'(g);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        note_result_t want;
        if (!rst_n) begin
            loop_len   = lsq_pkg::RST_LOOP_LENGTH;
            tgt_div    = lsq_pkg::RST_TARGET_DIVISION;
            snap_thr   = lsq_pkg::RST_SNAP_THRESHOLD;
            snap_grid  = lsq_pkg::RST_SNAP_MODE;
            held_grid  = 8'd1;
            grid_stale = 1'b1;
            quantized_notes.delete();
            failures = 0;
            outstanding <= 0;
        end
        else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    lsq_pkg::REG_LOOP_LENGTH:
                    begin
                        loop_len = cfg_data[lsq_pkg::STEP_W-1:0];
                        grid_stale = 1'b1;
                    end
                    lsq_pkg::REG_TARGET_DIVISION:
                    begin
                        tgt_div = cfg_data[lsq_pkg::GRID_W-1:0];
                        grid_stale = 1'b1;
                    end
                    lsq_pkg::REG_SNAP_THRESHOLD:
                        snap_thr = cfg_data[lsq_pkg::THR_W-1:0];
                    lsq_pkg::REG_SNAP_MODE:
                        snap_grid = cfg_data[0];
                endcase
            end

            // taken result against the oldest prediction
            if (results.valid && results.ready) begin
                if (quantized_notes.size() == 0) begin
                    $error("result with no note pending: snapped_step %0d",
                           results.snapped_step);
                    failures++;
                end
                else begin
                    want = quantized_notes.pop_front();
                    if (results.snapped_step !== want.step) begin
                        $error("snapped_step: expected %0d, got %0d",
                               want.step, results.snapped_step);
                        failures++;
                    end
                    if (results.quantized_duration !== want.qdur) begin
                        $error("quantized_duration: expected %0d, got %0d",
                               want.qdur, results.quantized_duration);
                        failures++;
                    end
                    if (results.grid_used !== want.grid) begin
                        $error("grid_used: expected %0d, got %0d",
                               want.grid, results.grid_used);
                        failures++;
                    end
                end
            end

            // taken note
            if (notes.valid && notes.ready)
                quantized_notes.push_back(quantize_note(notes.raw_step, notes.step_fraction,
                                                        notes.note_duration));

            outstanding <= quantized_notes.size();
        end
    end

endmodule

[tb/tb_loop_step_quantizer_core.sv]
// Testbench top for the loop step quantizer: clock, reset, note stimulus and verdict.
`timescale 1ns / 100ps

module tb_loop_step_quantizer_core;

    localparam int RANDOM_NOTES = 1450;
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_LIMIT = 20000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lsq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lsq_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             failures;
    int                             outstanding;
    bit                             gaps_on;
    logic [lsq_pkg::STEP_W-1:0]     cur_len;
    int                             random_sent;

    lsq_note_if   notes_if ();
    lsq_result_if results_if ();

    loop_step_quantizer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .notes     (notes_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    quantizer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .notes       (notes_if),
        .results     (results_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: stall in bursts while gaps are on
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            results_if.ready <= 1'b1;
        end
    end

    // one register write; the caller lowers cfg_we after the last one
    task automatic write_reg(input logic [lsq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsq_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_quantizer(input bit grid_regs,
                                     input logic [lsq_pkg::STEP_W-1:0] len,
                                     input logic [lsq_pkg::GRID_W-1:0] tgt,
                                     input logic [lsq_pkg::THR_W-1:0] thr, input logic mode);
        if (grid_regs) begin
            write_reg(lsq_pkg::REG_LOOP_LENGTH, {1'b0, len});
            write_reg(lsq_pkg::REG_TARGET_DIVISION, {1'b0, tgt});
            cur_len = len;
        end
        write_reg(lsq_pkg::REG_SNAP_THRESHOLD, thr);
        write_reg(lsq_pkg::REG_SNAP_MODE, {{(lsq_pkg::CFG_DATA_W-1){1'b0}}, mode});
        cfg_we <= 1'b0;
    endtask

    task automatic send_note(input logic [lsq_pkg::STEP_W-1:0] raw,
                             input logic [lsq_pkg::FRAC_W-1:0] frac,
                             input logic [lsq_pkg::DUR_W-1:0] dur);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            notes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        notes_if.valid         <= 1'b1;
        notes_if.raw_step      <= raw;
        notes_if.step_fraction <= frac;
        notes_if.note_duration <= dur;
        do @(posedge clk); while (!notes_if.ready);
    endtask

    // hold notes back until every predicted result is out, then let the block settle
    task automatic wait_drained;
        int waited;
        waited = 0;
        notes_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                         n_notes;
        int                         len_cap;
        bit                         grid_regs;
        logic [lsq_pkg::STEP_W-1:0] len;
        logic [lsq_pkg::GRID_W-1:0] tgt;
        logic [lsq_pkg::THR_W-1:0]  thr;
        logic                       mode;
        logic [lsq_pkg::STEP_W-1:0] raw;
        logic [lsq_pkg::FRAC_W-1:0] frac;
        logic [lsq_pkg::DUR_W-1:0]  dur;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        notes_if.valid = 1'b0;
        notes_if.raw_step = '0;
        notes_if.step_fraction = '0;
        notes_if.note_duration = '0;
        gaps_on = 1'b1;
        cur_len = lsq_pkg::RST_LOOP_LENGTH;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: grid 1, raw step zero and field extremes
        send_note(8'd0, 8'd0, 16'd0);
        send_note(8'd255, 8'd255, 16'hFFFF);
        send_note(8'd8, 8'd128, 16'd3);
        wait_drained();

        // grid 4 over 16 steps: forward snap, wrap, step past the loop, minimum duration
        program_quantizer(1'b1, 8'd16, 8'd4, 9'd128, 1'b1);
        send_note(8'd4, 8'd128, 16'd6);
        send_note(8'd16, 8'd200, 16'd2);
        send_note(8'd20, 8'd0, 16'd1);
        send_note(8'd1, 8'd0, 16'd0);
        send_note(8'hAA, 8'h55, 16'hAAAA);
        send_note(8'h55, 8'hAA, 16'h5555);
        wait_drained();

        // zero loop length, zero threshold: always forward, always wraps
        program_quantizer(1'b1, 8'd0, 8'd5, 9'd0, 1'b1);
        send_note(8'd3, 8'd0, 16'd7);
        send_note(8'd0, 8'd0, 16'd0);
        wait_drained();

        // zero target, threshold above one
        program_quantizer(1'b1, 8'd12, 8'd0, 9'd511, 1'b1);
        send_note(8'd5, 8'd255, 16'd9);
        wait_drained();

        // step mode at the largest loop
        program_quantizer(1'b1, 8'd255, 8'd255, 9'd256, 1'b0);
        send_note(8'd255, 8'd255, 16'hFFFF);
        send_note(8'd100, 8'd10, 16'd500);
        wait_drained();

        // largest grid, then grid 85
        program_quantizer(1'b1, 8'd255, 8'd255, 9'd128, 1'b1);
        send_note(8'd200, 8'd77, 16'd127);
        send_note(8'd1, 8'd255, 16'hFFFF);
        wait_drained();
        program_quantizer(1'b1, 8'd255, 8'd254, 9'd128, 1'b1);
        send_note(8'd255, 8'd0, 16'hFFFF);
        send_note(8'd43, 8'd128, 16'd42);
        wait_drained();

        // random phases; some rewrite only threshold and mode so the grid is held
        while (random_sent < RANDOM_NOTES) begin
            grid_regs = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 7))
                0: len = 8'd0;
                1: len = 8'd255;
                2: len = 8'd1;
                3: len = lsq_pkg::STEP_W'($urandom_range(1, 255));
                default: len = lsq_pkg::STEP_W'($urandom_range(1, 16) * $urandom_range(1, 15));
            endcase
            case ($urandom_range(0, 7))
                0: tgt = 8'd0;
                1: tgt = 8'd255;
                2: tgt = lsq_pkg::GRID_W'($urandom_range(1, 255));
                default: tgt = lsq_pkg::GRID_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 7))
                0: thr = 9'd0;
                1: thr = 9'd256;
                2: thr = lsq_pkg::THR_W'($urandom_range(257, 511));
                default: thr = lsq_pkg::THR_W'($urandom_range(0, 255));
            endcase
            mode = ($urandom_range(0, 3) != 0);
            program_quantizer(grid_regs, len, tgt, thr, mode);

            n_notes = $urandom_range(20, 120);
            len_cap = (cur_len == 0) ? 1 : cur_len;
            for (int i = 0; i < n_notes && random_sent < RANDOM_NOTES; i++) begin
                gaps_on = (random_sent < RANDOM_NOTES * 85 / 100);
                case ($urandom_range(0, 9))
                    0: raw = 8'd0;
                    1: raw = 8'd255;
                    2: raw = lsq_pkg::STEP_W'($urandom_range(0, 255));
                    default: raw = lsq_pkg::STEP_W'($urandom_range(1, len_cap));
                endcase
                case ($urandom_range(0, 7))
                    0: frac = 8'd0;
                    1: frac = 8'd255;
                    default: frac = lsq_pkg::FRAC_W'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 9))
                    0: dur = lsq_pkg::DUR_W'($urandom_range(0, 65535));
                    1: dur = 16'hFFFF;
                    2: dur = 16'd0;
                    default: dur = lsq_pkg::DUR_W'($urandom_range(0, 1000));
                endcase
                send_note(raw, frac, dur);
                random_sent++;
            end
            wait_drained();
        end

        if (outstanding != 0)
            $error("%0d predicted results never arrived", outstanding);
        if (failures == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
